// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the packet queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/bpq_pkg.sv =====
// Package with the types and constants of the bounded packet queue.
package bpq_pkg;

	// Queue geometry.
	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int GRP    = 8;
	localparam int NGRP   = DEPTH / GRP;
	localparam int GCNT_W = $clog2(GRP + 1);

	// Fixed field widths.
	localparam int CAP_W   = 7;
	localparam int MCNT_W  = 7;
	localparam int CAP_RST = 64;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_FWD = 2'd1,
		OP_CNT = 2'd2,
		OP_RSV = 2'd3
	} bpq_op_t;

	typedef enum logic [2:0] {
		ST_ADDED = 3'd0,
		ST_DUP   = 3'd1,
		ST_FWD   = 3'd2,
		ST_EMPTY = 3'd3,
		ST_COUNT = 3'd4
	} bpq_status_t;

	// One stored packet.
	typedef struct packed {
		logic [15:0] src;
		logic [15:0] dst;
		logic [31:0] ts;
	} bpq_entry_t;

	// Query presented to every cell.
	typedef struct packed {
		bpq_entry_t  entry;
		logic [31:0] lo;
		logic [31:0] hi;
	} bpq_qry_t;

	// Update control broadcast along the chain.
	typedef struct packed {
		logic             upd;
		logic             shift;
		logic             wr;
		logic [IDX_W-1:0] wr_idx;
	} bpq_ctl_t;

endpackage

// ===== rtl/core/bounded_packet_queue_dedup_count_unit.sv =====
// Top level of the bounded packet queue with duplicate filter and range count.
//
// Commands enter on the s_ channel: s_tuser carries the opcode (add, forward,
// count) and s_tdata the packet and query fields. Each command yields exactly
// one result transaction on the m_ channel: m_tuser carries the status and
// m_tdata the forwarded packet and the match count.
// The queue is a row of cells, oldest packet in cell zero. Every cell compares
// its packet with the command in parallel; the duplicate flags and range hits
// are reduced in two registered steps.
// The command passes the command register, the group registers of the first
// reduction step and the output register. A new command enters only while idle
// or as the last one retires in the final step, which also writes the cells.
// The user writes the capacity register through cfg_we and cfg_wdata while
// idle; the block itself does not enforce it. Reset empties the queue, sets
// the capacity to 64 and clears m_tvalid. A stalled receiver holds the result
// in the output register; the block waits in its last step until it leaves.
`include "assert_macros.svh"

module bounded_packet_queue_dedup_count_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	// Command channel.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// s_tdata: source[15:0], destination[31:16], timestamp[63:32],
	// start_time[95:64], end_time[127:96].
	input  logic [127:0]              s_tdata,
	// s_tuser: opcode[1:0].
	input  logic [1:0]                s_tuser,
	// Result channel.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// m_tdata: out_source[15:0], out_destination[31:16], out_timestamp[63:32],
	// match_count[70:64], zero[71].
	output logic [71:0]               m_tdata,
	// m_tuser: status[2:0].
	output logic [2:0]                m_tuser,
	// Capacity register write.
	input  logic                      cfg_we,
	input  logic [bpq_pkg::CAP_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_REDUCE = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		bpq_pkg::bpq_op_t op;
		bpq_pkg::bpq_qry_t qry;
	} cmd_t;

	state_t                     state_q, state_d;
	cmd_t                       cmd_q;
	logic [bpq_pkg::CAP_W-1:0]  cap_q;
	logic [bpq_pkg::CNT_W-1:0]  occ_q, occ_d;
	logic [bpq_pkg::CNT_W-1:0]  eff_cap;
	logic                       accept, out_free, upd, dup_any, evict;
	logic [bpq_pkg::CNT_W-1:0]  cnt_sum;
	bpq_pkg::bpq_ctl_t          ctl;
	bpq_pkg::bpq_entry_t        head;
	logic [bpq_pkg::NGRP-1:0]   grp_dup_s1;
	logic [bpq_pkg::GCNT_W-1:0] grp_cnt_s1 [bpq_pkg::NGRP];

	bpq_pkg::bpq_status_t        status_d;
	bpq_pkg::bpq_entry_t         fwd_d;
	logic [bpq_pkg::MCNT_W-1:0]  mcnt_d;
	logic                        m_tvalid_q;
	bpq_pkg::bpq_status_t        status_q;
	bpq_pkg::bpq_entry_t         fwd_q;
	logic [bpq_pkg::MCNT_W-1:0]  mcnt_q;

	// Handshake: a new command enters while idle or while the last step retires.
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) || ((state_q == S_FINISH) && out_free);
	assign accept   = s_tvalid && s_tready;
	assign upd      = (state_q == S_FINISH) && out_free;

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_REDUCE;
			end
			S_REDUCE: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = accept ? S_REDUCE : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command register.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op           <= bpq_pkg::bpq_op_t'(s_tuser);
			cmd_q.qry.entry.src <= s_tdata[15:0];
			cmd_q.qry.entry.dst <= s_tdata[31:16];
			cmd_q.qry.entry.ts  <= s_tdata[63:32];
			cmd_q.qry.lo       <= s_tdata[95:64];
			cmd_q.qry.hi       <= s_tdata[127:96];
		end
	end

	// Capacity register and its effective value, clamped to one through DEPTH.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bpq_pkg::CAP_W'(bpq_pkg::CAP_RST);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = bpq_pkg::CNT_W'(1);
		end else if (32'(cap_q) > 32'(bpq_pkg::DEPTH)) begin
			eff_cap = bpq_pkg::CNT_W'(bpq_pkg::DEPTH);
		end else begin
			eff_cap = bpq_pkg::CNT_W'(cap_q);
		end
	end

	// Final reduction of the group results.
	always_comb begin
		cnt_sum = '0;
		dup_any = |grp_dup_s1;
		for (int g = 0; g < bpq_pkg::NGRP; g++) begin
			cnt_sum = cnt_sum + bpq_pkg::CNT_W'(grp_cnt_s1[g]);
		end
	end

	// Command decode: cell update, new occupancy and result fields.
	always_comb begin
		evict      = occ_q >= eff_cap;
		ctl.upd    = upd;
		ctl.shift  = 1'b0;
		ctl.wr     = 1'b0;
		ctl.wr_idx = bpq_pkg::IDX_W'(occ_q);
		occ_d      = occ_q;
		status_d   = bpq_pkg::ST_COUNT;
		fwd_d      = '0;
		mcnt_d     = '0;
		case (cmd_q.op)
			bpq_pkg::OP_ADD: begin
				if (dup_any) begin
					status_d = bpq_pkg::ST_DUP;
				end else begin
					status_d = bpq_pkg::ST_ADDED;
					ctl.wr   = 1'b1;
					if (evict) begin
						ctl.shift  = 1'b1;
						ctl.wr_idx = bpq_pkg::IDX_W'(occ_q - 1'b1);
					end else begin
						occ_d = occ_q + 1'b1;
					end
				end
			end
			bpq_pkg::OP_FWD: begin
				if (occ_q == '0) begin
					status_d = bpq_pkg::ST_EMPTY;
				end else begin
					status_d  = bpq_pkg::ST_FWD;
					fwd_d     = head;
					ctl.shift = 1'b1;
					occ_d     = occ_q - 1'b1;
				end
			end
			bpq_pkg::OP_CNT: begin
				mcnt_d = bpq_pkg::MCNT_W'(cnt_sum);
			end
			default: begin
				status_d = bpq_pkg::ST_COUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (upd) begin
			occ_q <= occ_d;
		end
	end

	// Cell row.
	bpq_chain u_chain (
		.clk        (clk),
		.occ        (occ_q),
		.ctl        (ctl),
		.qry        (cmd_q.qry),
		.head       (head),
		.grp_dup_s1 (grp_dup_s1),
		.grp_cnt_s1 (grp_cnt_s1)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (upd) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			status_q <= status_d;
			fwd_q    <= fwd_d;
			mcnt_q   <= mcnt_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {1'b0, mcnt_q, fwd_q.ts, fwd_q.dst, fwd_q.src};

	// Checks on the sequencer and the occupancy.
	`ASSERT_IMPL(a_occ_bound, 1'b1, occ_q <= bpq_pkg::CNT_W'(bpq_pkg::DEPTH))
	`ASSERT_IMPL(a_busy_no_ready, state_q == S_REDUCE, !s_tready)
	`ASSERT_NEXT(a_accept_reduce, s_tvalid && s_tready, state_q == S_REDUCE)
	`ASSERT_NEXT(a_fwd_pops, upd && (cmd_q.op == bpq_pkg::OP_FWD) && (occ_q != '0),
		(occ_q + 1'b1) == $past(occ_q))

endmodule

// ===== rtl/core/bpq_cell.sv =====
// One queue cell: holds a packet, compares it with the query, shifts toward the head.
module bpq_cell (
	input  logic                      clk,
	input  logic [bpq_pkg::IDX_W-1:0] idx,
	input  logic [bpq_pkg::CNT_W-1:0] occ,
	input  bpq_pkg::bpq_ctl_t         ctl,
	input  bpq_pkg::bpq_qry_t         qry,
	input  bpq_pkg::bpq_entry_t       nbr,
	output bpq_pkg::bpq_entry_t       entry,
	output logic                      dup,
	output logic                      hit
);

	bpq_pkg::bpq_entry_t entry_q;
	logic                live;

	// The cell holds a live packet when its place is below the occupancy.
	assign live  = bpq_pkg::CNT_W'(idx) < occ;
	assign dup   = live && (entry_q == qry.entry);
	assign hit   = live && (entry_q.dst == qry.entry.dst)
		&& (entry_q.ts >= qry.lo) && (entry_q.ts <= qry.hi);
	assign entry = entry_q;

	// A write into this place wins over the shift from the neighbor above.
	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			if (ctl.wr && (ctl.wr_idx == idx)) begin
				entry_q <= qry.entry;
			end else if (ctl.shift) begin
				entry_q <= nbr;
			end
		end
	end

endmodule

// ===== rtl/core/bpq_chain.sv =====
// Row of queue cells with a registered first level of the match reduction.
module bpq_chain (
	input  logic                       clk,
	input  logic [bpq_pkg::CNT_W-1:0]  occ,
	input  bpq_pkg::bpq_ctl_t          ctl,
	input  bpq_pkg::bpq_qry_t          qry,
	output bpq_pkg::bpq_entry_t        head,
	output logic [bpq_pkg::NGRP-1:0]   grp_dup_s1,
	output logic [bpq_pkg::GCNT_W-1:0] grp_cnt_s1 [bpq_pkg::NGRP]
);

	bpq_pkg::bpq_entry_t entry_w [bpq_pkg::DEPTH];
	bpq_pkg::bpq_entry_t nbr_w   [bpq_pkg::DEPTH];
	logic [bpq_pkg::DEPTH-1:0] dup_w;
	logic [bpq_pkg::DEPTH-1:0] hit_w;

	// Cell zero holds the oldest packet; data moves down one place on a forward or an eviction.
	for (genvar g = 0; g < bpq_pkg::DEPTH; g++) begin : g_cell
		if (g == bpq_pkg::DEPTH - 1) begin : g_top
			assign nbr_w[g] = entry_w[g];
		end else begin : g_mid
			assign nbr_w[g] = entry_w[g+1];
		end

		bpq_cell u_cell (
			.clk   (clk),
			.idx   (bpq_pkg::IDX_W'(g)),
			.occ   (occ),
			.ctl   (ctl),
			.qry   (qry),
			.nbr   (nbr_w[g]),
			.entry (entry_w[g]),
			.dup   (dup_w[g]),
			.hit   (hit_w[g])
		);
	end

	assign head = entry_w[0];

	// Per-group duplicate flag and hit count, registered.
	for (genvar gi = 0; gi < bpq_pkg::NGRP; gi++) begin : g_grp
		logic [bpq_pkg::GCNT_W-1:0] cnt_w;
		logic                       any_w;

		always_comb begin
			cnt_w = '0;
			any_w = 1'b0;
			for (int k = 0; k < bpq_pkg::GRP; k++) begin
				cnt_w = cnt_w + bpq_pkg::GCNT_W'(hit_w[gi*bpq_pkg::GRP + k]);
				any_w = any_w | dup_w[gi*bpq_pkg::GRP + k];
			end
		end

		always_ff @(posedge clk) begin
			grp_cnt_s1[gi] <= cnt_w;
			grp_dup_s1[gi] <= any_w;
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench for the bounded packet queue: directed table, random commands, self-checking.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// One command as it enters the s_ channel.
	typedef struct {
		bpq_pkg::bpq_op_t op;
		logic [15:0]      src;
		logic [15:0]      dst;
		logic [31:0]      ts;
		logic [31:0]      lo;
		logic [31:0]      hi;
	} queue_cmd_t;

	// One result as it leaves the m_ channel.
	typedef struct {
		bpq_pkg::bpq_status_t       status;
		logic [15:0]                src;
		logic [15:0]                dst;
		logic [31:0]                ts;
		logic [bpq_pkg::MCNT_W-1:0] mcnt;
	} queue_result_t;

	// One row of the directed table: a capacity write or a command.
	typedef struct {
		bit            is_cfg;
		logic [6:0]    cfg_val;
		queue_cmd_t    cmd;
		bit            typed;
		queue_result_t res;
	} dir_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	// s_tdata: source[15:0], destination[31:16], timestamp[63:32],
	// start_time[95:64], end_time[127:96].
	logic [127:0]              s_tdata = '0;
	// s_tuser: opcode[1:0].
	logic [1:0]                s_tuser = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	// m_tdata: out_source[15:0], out_destination[31:16], out_timestamp[63:32],
	// match_count[70:64], zero[71].
	logic [71:0]               m_tdata;
	// m_tuser: status[2:0].
	logic [2:0]                m_tuser;
	logic                      cfg_we = 1'b0;
	logic [bpq_pkg::CAP_W-1:0] cfg_wdata = '0;

	// Predictor state: stored packets oldest first, and the capacity register.
	bpq_pkg::bpq_entry_t       model_pkts[$];
	logic [bpq_pkg::CAP_W-1:0] model_cap = bpq_pkg::CAP_W'(bpq_pkg::CAP_RST);
	queue_result_t             pending_results[$];
	logic [31:0]               time_now = 32'd100;
	int                        err_count = 0;
	int unsigned               send_idle = 0;
	int unsigned               recv_idle = 0;
	queue_result_t             seen_res;
	queue_result_t             want_res;
	dir_row_t                  dir_rows[$];

	bounded_packet_queue_dedup_count_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Effective capacity and one command applied to the predicted queue.
	function automatic queue_result_t predict_queue_result(input queue_cmd_t c);
		queue_result_t       r;
		bpq_pkg::bpq_entry_t e;
		int                  cap;
		int                  n;
		r = '{bpq_pkg::ST_ADDED, 16'd0, 16'd0, 32'd0, 7'd0};
		cap = int'(model_cap);
		if (cap == 0) cap = 1;
		if (cap > bpq_pkg::DEPTH) cap = bpq_pkg::DEPTH;
		case (c.op)
			bpq_pkg::OP_ADD: begin
				e = '{c.src, c.dst, c.ts};
				foreach (model_pkts[k]) begin
					if (model_pkts[k] == e) r.status = bpq_pkg::ST_DUP;
				end
				if (r.status != bpq_pkg::ST_DUP) begin
					if (model_pkts.size() >= cap) model_pkts.delete(0);
					model_pkts = {model_pkts, e};
				end
			end
			bpq_pkg::OP_FWD: begin
				if (model_pkts.size() == 0) begin
					r.status = bpq_pkg::ST_EMPTY;
				end else begin
					e = model_pkts[0];
					model_pkts.delete(0);
					r.status = bpq_pkg::ST_FWD;
					r.src = e.src;
					r.dst = e.dst;
					r.ts = e.ts;
				end
			end
			bpq_pkg::OP_CNT: begin
				n = 0;
				foreach (model_pkts[k]) begin
					if (model_pkts[k].dst == c.dst && model_pkts[k].ts >= c.lo &&
						model_pkts[k].ts <= c.hi) n++;
				end
				r.status = bpq_pkg::ST_COUNT;
				r.mcnt = bpq_pkg::MCNT_W'(n);
			end
			default: begin
				r.status = bpq_pkg::ST_COUNT;
			end
		endcase
		return r;
	endfunction

	// Random command: mostly small id pools and rising time, so that duplicates,
	// evictions and count hits are frequent; some fully random fields as noise.
	function automatic queue_cmd_t make_random_cmd();
		queue_cmd_t          c;
		bpq_pkg::bpq_entry_t p1;
		bpq_pkg::bpq_entry_t p2;
		logic [31:0]         tmp;
		int unsigned         roll;
		roll = $urandom_range(99);
		c.src = 16'($urandom);
		c.dst = 16'($urandom);
		c.ts = $urandom;
		c.lo = $urandom;
		c.hi = $urandom;
		if (roll < 50) begin
			c.op = bpq_pkg::OP_ADD;
			if (model_pkts.size() != 0 && $urandom_range(99) < 15) begin
				p1 = model_pkts[$urandom_range(model_pkts.size() - 1)];
				c.src = p1.src;
				c.dst = p1.dst;
				c.ts = p1.ts;
			end else begin
				if ($urandom_range(9) != 0) begin
					c.src = 16'($urandom_range(3));
					c.dst = 16'($urandom_range(3));
				end
				if ($urandom_range(29) != 0) begin
					time_now = time_now + $urandom_range(1);
					c.ts = time_now;
				end
			end
		end else if (roll < 75) begin
			c.op = bpq_pkg::OP_FWD;
		end else if (roll < 95) begin
			c.op = bpq_pkg::OP_CNT;
			if (model_pkts.size() != 0 && $urandom_range(9) != 0) begin
				p1 = model_pkts[$urandom_range(model_pkts.size() - 1)];
				p2 = model_pkts[$urandom_range(model_pkts.size() - 1)];
				c.dst = p1.dst;
				c.lo = (p1.ts < p2.ts) ? p1.ts : p2.ts;
				c.hi = (p1.ts < p2.ts) ? p2.ts : p1.ts;
				// Now and then an inverted range.
				if ($urandom_range(9) == 0) begin
					tmp = c.lo;
					c.lo = c.hi;
					c.hi = tmp;
				end
			end
		end else begin
			c.op = bpq_pkg::OP_RSV;
		end
		return c;
	endfunction

	function automatic dir_row_t dir_cmd(input bpq_pkg::bpq_op_t op, input logic [15:0] src,
		input logic [15:0] dst, input logic [31:0] ts, input logic [31:0] lo,
		input logic [31:0] hi);
		dir_row_t r;
		r.is_cfg = 1'b0;
		r.cfg_val = '0;
		r.cmd = '{op, src, dst, ts, lo, hi};
		r.typed = 1'b0;
		r.res = '{bpq_pkg::ST_ADDED, 16'd0, 16'd0, 32'd0, 7'd0};
		return r;
	endfunction

	function automatic dir_row_t dir_chk(input bpq_pkg::bpq_op_t op, input logic [15:0] src,
		input logic [15:0] dst, input logic [31:0] ts, input logic [31:0] lo,
		input logic [31:0] hi, input bpq_pkg::bpq_status_t st, input logic [15:0] osrc,
		input logic [15:0] odst, input logic [31:0] ots, input logic [6:0] mc);
		dir_row_t r;
		r = dir_cmd(op, src, dst, ts, lo, hi);
		r.typed = 1'b1;
		r.res = '{st, osrc, odst, ots, mc};
		return r;
	endfunction

	function automatic dir_row_t dir_cfg(input logic [6:0] v);
		dir_row_t r;
		r = dir_cmd(bpq_pkg::OP_RSV, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
		r.is_cfg = 1'b1;
		r.cfg_val = v;
		return r;
	endfunction

	// Add one row at the end of the directed table.
	function automatic void append_row(input dir_row_t r);
		dir_rows = {dir_rows, r};
	endfunction

	// Present one command and hold it until the transaction takes place.
	// The expectation is queued up front; the result cannot come before acceptance.
	task automatic issue_cmd(input queue_cmd_t c, input bit typed, input queue_result_t tres);
		queue_result_t r;
		logic          rdy;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		r = predict_queue_result(c);
		if (typed) r = tres;
		pending_results = {pending_results, r};
		s_tvalid <= 1'b1;
		s_tuser <= c.op;
		s_tdata <= {c.hi, c.lo, c.ts, c.dst, c.src};
		// Ready is sampled mid-cycle, where it is stable.
		forever begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
			if (rdy) break;
		end
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic wait_results_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Capacity write, only with the block idle.
	task automatic write_capacity(input logic [6:0] v);
		wait_results_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_cap = v;
	endtask

	// Receiver back-pressure.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Result checking: a transaction takes place at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_res.status = bpq_pkg::bpq_status_t'(m_tuser);
			seen_res.src = m_tdata[15:0];
			seen_res.dst = m_tdata[31:16];
			seen_res.ts = m_tdata[63:32];
			seen_res.mcnt = m_tdata[70:64];
			if (pending_results.size() == 0) begin
				$error("result transaction with no command outstanding");
				err_count++;
			end else begin
				want_res = pending_results[0];
				pending_results.delete(0);
				if (seen_res.status != want_res.status) begin
					$error("status expected %0d actual %0d", want_res.status, seen_res.status);
					err_count++;
				end
				if (seen_res.src != want_res.src) begin
					$error("out_source expected %0h actual %0h", want_res.src, seen_res.src);
					err_count++;
				end
				if (seen_res.dst != want_res.dst) begin
					$error("out_destination expected %0h actual %0h",
						want_res.dst, seen_res.dst);
					err_count++;
				end
				if (seen_res.ts != want_res.ts) begin
					$error("out_timestamp expected %0h actual %0h", want_res.ts, seen_res.ts);
					err_count++;
				end
				if (seen_res.mcnt != want_res.mcnt) begin
					$error("match_count expected %0d actual %0d",
						want_res.mcnt, seen_res.mcnt);
					err_count++;
				end
			end
		end
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAIL bounded_packet_queue_dedup_count_unit");
		$finish;
	end

	// Stimulus.
	initial begin
		logic [6:0] caps[9];
		int         seg;
		caps = '{7'd64, 7'd1, 7'd5, 7'd127, 7'd0, 7'd3, 7'd64, 7'd17, 7'd2};

		// Directed table: empty queue, field extremes, duplicates, capacity corners.
		append_row(dir_chk(bpq_pkg::OP_FWD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
			bpq_pkg::ST_EMPTY, 16'd0, 16'd0, 32'd0, 7'd0));
		append_row(dir_chk(bpq_pkg::OP_CNT, 16'd0, 16'd0, 32'd0, 32'd0, 32'hFFFFFFFF,
			bpq_pkg::ST_COUNT, 16'd0, 16'd0, 32'd0, 7'd0));
		append_row(dir_chk(bpq_pkg::OP_ADD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
			bpq_pkg::ST_ADDED, 16'd0, 16'd0, 32'd0, 7'd0));
		append_row(dir_chk(bpq_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'd0, 32'd0,
			bpq_pkg::ST_ADDED, 16'd0, 16'd0, 32'd0, 7'd0));
		append_row(dir_chk(bpq_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'd0, 32'd0,
			bpq_pkg::ST_DUP, 16'd0, 16'd0, 32'd0, 7'd0));
		append_row(dir_cmd(bpq_pkg::OP_ADD, 16'hFFFF, 16'd0, 32'hFFFFFFFF, 32'd0, 32'd0));
		append_row(dir_cmd(bpq_pkg::OP_CNT, 16'd0, 16'hFFFF, 32'd0, 32'd0, 32'hFFFFFFFF));
		// Inverted range counts nothing.
		append_row(dir_chk(bpq_pkg::OP_CNT, 16'd0, 16'd0, 32'd0, 32'hFFFFFFFF, 32'd0,
			bpq_pkg::ST_COUNT, 16'd0, 16'd0, 32'd0, 7'd0));
		// Unused opcode answers with an empty count.
		append_row(dir_chk(bpq_pkg::OP_RSV, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, bpq_pkg::ST_COUNT, 16'd0, 16'd0, 32'd0, 7'd0));
		append_row(dir_chk(bpq_pkg::OP_FWD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
			bpq_pkg::ST_FWD, 16'd0, 16'd0, 32'd0, 7'd0));
		append_row(dir_chk(bpq_pkg::OP_FWD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
			bpq_pkg::ST_FWD, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 7'd0));
		// Capacity one: eviction, and a duplicate of the oldest while full.
		append_row(dir_cfg(7'd1));
		append_row(dir_cmd(bpq_pkg::OP_ADD, 16'd1, 16'd2, 32'd10, 32'd0, 32'd0));
		append_row(dir_chk(bpq_pkg::OP_ADD, 16'd1, 16'd2, 32'd10, 32'd0, 32'd0,
			bpq_pkg::ST_DUP, 16'd0, 16'd0, 32'd0, 7'd0));
		// Capacity zero behaves as one.
		append_row(dir_cfg(7'd0));
		append_row(dir_cmd(bpq_pkg::OP_ADD, 16'd3, 16'd2, 32'd11, 32'd0, 32'd0));
		append_row(dir_cmd(bpq_pkg::OP_FWD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));
		// Capacity above the depth saturates.
		append_row(dir_cfg(7'd127));
		append_row(dir_cmd(bpq_pkg::OP_ADD, 16'd4, 16'd5, 32'd20, 32'd0, 32'd0));
		append_row(dir_cmd(bpq_pkg::OP_ADD, 16'd4, 16'd5, 32'd21, 32'd0, 32'd0));
		append_row(dir_cmd(bpq_pkg::OP_ADD, 16'd4, 16'd5, 32'd22, 32'd0, 32'd0));
		// Capacity lowered below occupancy: one eviction per add.
		append_row(dir_cfg(7'd2));
		append_row(dir_cmd(bpq_pkg::OP_ADD, 16'd4, 16'd5, 32'd23, 32'd0, 32'd0));
		append_row(dir_cmd(bpq_pkg::OP_CNT, 16'd0, 16'd5, 32'd0, 32'd21, 32'd23));
		append_row(dir_cmd(bpq_pkg::OP_FWD, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0));

		// Single reset at the start.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 8;
		recv_idle = 46;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_capacity(dir_rows[i].cfg_val);
			end else begin
				issue_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
			end
		end

		// Random phases, each under its own capacity and idling pattern.
		for (seg = 0; seg < 9; seg++) begin
			if (seg < 3) begin
				send_idle = 8;
				recv_idle = 46;
			end else if (seg < 6) begin
				send_idle = 46;
				recv_idle = 8;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_capacity(caps[seg]);
			for (int i = 0; i < 83; i++) begin
				// Let the block run dry once in the middle of a phase.
				if (seg == 4 && i == 40) wait_results_idle();
				issue_cmd(make_random_cmd(), 1'b0,
					'{bpq_pkg::ST_ADDED, 16'd0, 16'd0, 32'd0, 7'd0});
			end
		end

		// Drain and let the pipeline settle.
		wait_results_idle();
		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("PASS bounded_packet_queue_dedup_count_unit");
		end else begin
			$display("FAIL bounded_packet_queue_dedup_count_unit");
		end
		$finish;
	end

endmodule

// ===== bounded_packet_queue_dedup_count_unit.f =====
+incdir+rtl/core
rtl/core/bpq_pkg.sv
rtl/core/bpq_cell.sv
rtl/core/bpq_chain.sv
rtl/core/bounded_packet_queue_dedup_count_unit.sv
test/tb_top.sv
